// ===== hdl/phd_pkg.sv =====
package phd_pkg;

  // Node table geometry
  localparam int unsigned TreeNodes  = 512;
  localparam int unsigned NodeAw     = $clog2(TreeNodes);
  localparam int unsigned NodeCw     = NodeAw + 1;        // node count, holds TreeNodes
  localparam int unsigned EntryW     = NodeAw + 1;        // leaf flag + pointer/symbol
  localparam int unsigned LeafBit    = NodeAw;

  // Pending stack of internal nodes awaiting their one subtree
  localparam int unsigned StackDepth = TreeNodes / 2;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned StackCw    = StackAw + 1;

  localparam int unsigned SymW        = 8;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCw       = $clog2(BitsPerByte) + 1;
  localparam int unsigned SymCw       = $clog2(SymW + 1) + 1;

  // Front-to-back queue, power of two deep
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // Action codes
  localparam logic [1:0] ActData  = 2'd0;
  localparam logic [1:0] ActBegin = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  // Result status codes
  localparam logic [1:0] StData       = 2'd0;
  localparam logic [1:0] StOverflow   = 2'd1;
  localparam logic [1:0] StSingleLeaf = 2'd2;

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_TREE,
    PH_DECODE,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BITS,
    BK_CLOSE,
    BK_FLUSH
  } back_state_e;

  typedef enum logic [1:0] {
    IT_DATA,
    IT_BEGIN,
    IT_END,
    IT_NOP
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [SymW-1:0]   data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== hdl/phd_if.sv =====
interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface phd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

// ===== hdl/phd_front.sv =====
module phd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  phd_in_if.sink         in_i,
  output phd_pkg::head_t head_o,
  input  logic           pop_i
);
  import phd_pkg::*;

  item_t              q_mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   cnt_q, cnt_d;
  logic               accept;
  item_t              in_item;

  assign in_i.ready = (cnt_q != (QueueAw + 1)'(QueueDepth));
  assign accept     = in_i.valid && in_i.ready;

  // classify the action once, here
  always_comb begin
    in_item.data = in_i.data_byte;
    unique case (in_i.action)
      ActData:  in_item.kind = IT_DATA;
      ActBegin: in_item.kind = IT_BEGIN;
      ActEnd:   in_item.kind = IT_END;
      default:  in_item.kind = IT_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_d = accept ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({accept, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

endmodule

// ===== hdl/phd_back.sv =====
module phd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  phd_pkg::head_t head_i,
  output logic           pop_o,
  phd_out_if.source      out_o
);
  import phd_pkg::*;

  // storage
  logic [EntryW-1:0]  tbl_mem [TreeNodes];
  logic [NodeAw-1:0]  stk_mem [StackDepth];

  back_state_e        bk_q, bk_d;
  phase_e             phase_q, phase_d;
  logic [NodeCw-1:0]  nodes_q, nodes_d;
  logic [StackCw-1:0] stk_top_q, stk_top_d;
  logic [NodeAw-1:0]  walk_q, walk_d;
  logic [NodeAw-1:0]  c1_q, c1_d;          // one-child pointer of walk node
  logic [NodeAw-1:0]  root_c1_q, root_c1_d;
  logic               root_leaf_q, root_leaf_d;
  logic [SymW-1:0]    sym_q, sym_d;
  logic [SymCw-1:0]   symcnt_q, symcnt_d;
  logic [SymW-1:0]    bits_q, bits_d;
  logic [BitCw-1:0]   cnt_q, cnt_d;
  logic               rdv_q, rdv_d;
  logic               hold_v_q, hold_v_d;
  logic [SymW-1:0]    hold_byte_q, hold_byte_d;
  logic [1:0]         hold_st_q, hold_st_d;
  logic               out_v_q, out_v_d;
  logic [SymW-1:0]    out_byte_q, out_byte_d;
  logic [1:0]         out_st_q, out_st_d;
  logic               out_last_q, out_last_d;

  // memory ports
  logic               tbl_we;
  logic [NodeAw-1:0]  tbl_wa;
  logic [EntryW-1:0]  tbl_wd;
  logic [NodeAw-1:0]  tbl_ra_a, tbl_ra_b;
  logic [EntryW-1:0]  ra_q, rb_q;
  logic               stk_we;
  logic [StackAw-1:0] stk_wa;
  logic [NodeAw-1:0]  stk_wd;
  logic [StackAw-1:0] stk_ra;
  logic [NodeAw-1:0]  stk_rd_q;

  logic               bit_in;
  logic               slot_free;
  logic               emit_ok;
  logic               emit;
  logic [SymW-1:0]    em_byte;
  logic [1:0]         em_st;
  logic               push;
  logic [SymW-1:0]    push_byte;
  logic [1:0]         push_st;
  logic               push_last;
  logic               consume;
  logic [NodeCw-1:0]  nodes_m1;
  logic [EntryW-1:0]  ne;
  logic [NodeAw-1:0]  nxt;

  assign bit_in    = bits_q[SymW-1];
  assign slot_free = !out_v_q || out_o.ready;
  assign emit_ok   = !hold_v_q || slot_free;
  assign nodes_m1  = nodes_q - 1'b1;
  assign ne        = bit_in ? rb_q : ra_q;
  assign nxt       = bit_in ? c1_q : walk_q + 1'b1;
  assign stk_ra    = stk_top_q[StackAw-1:0] - 1'b1;

  always_comb begin
    bk_d        = bk_q;
    phase_d     = phase_q;
    nodes_d     = nodes_q;
    stk_top_d   = stk_top_q;
    walk_d      = walk_q;
    c1_d        = c1_q;
    sym_d       = sym_q;
    symcnt_d    = symcnt_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    hold_v_d    = hold_v_q;
    hold_byte_d = hold_byte_q;
    hold_st_d   = hold_st_q;
    pop_o       = 1'b0;
    tbl_we      = 1'b0;
    tbl_wa      = '0;
    tbl_wd      = '0;
    stk_we      = 1'b0;
    stk_wa      = stk_top_q[StackAw-1:0];
    stk_wd      = nodes_q[NodeAw-1:0];
    emit        = 1'b0;
    em_byte     = '0;
    em_st       = StData;
    push        = 1'b0;
    push_byte   = hold_byte_q;
    push_st     = hold_st_q;
    push_last   = 1'b0;
    consume     = 1'b0;

    unique case (bk_q)
      BK_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.item.kind)
            IT_BEGIN: begin
              nodes_d   = '0;
              stk_top_d = '0;
              symcnt_d  = '0;
              sym_d     = '0;
              walk_d    = '0;
              c1_d      = root_c1_q;
              phase_d   = PH_TREE;
            end
            IT_END: begin
              symcnt_d = '0;
              sym_d    = '0;
              walk_d   = '0;
              c1_d     = root_c1_q;
              phase_d  = PH_PLAIN;
            end
            IT_DATA: begin
              unique case (phase_q)
                PH_PLAIN: begin
                  emit    = 1'b1;
                  em_byte = head_i.item.data;
                  bk_d    = BK_FLUSH;
                end
                PH_TREE, PH_DECODE: begin
                  bits_d = head_i.item.data;
                  cnt_d  = '0;
                  bk_d   = BK_BITS;
                end
                default: ;   // halted: byte dropped
              endcase
            end
            default: ;
          endcase
        end
      end

      BK_BITS: begin
        unique case (phase_q)
          PH_TREE: begin
            if (symcnt_q != '0) begin
              sym_d   = {sym_q[SymW-2:0], bit_in};
              consume = 1'b1;
              if (symcnt_q == SymCw'(SymW)) begin
                tbl_we   = 1'b1;
                tbl_wa   = nodes_m1[NodeAw-1:0];
                tbl_wd   = {1'b1, NodeAw'({sym_q[SymW-2:0], bit_in})};
                symcnt_d = '0;
                sym_d    = '0;
                bk_d     = BK_CLOSE;
              end else begin
                symcnt_d = symcnt_q + 1'b1;
              end
            end else if (nodes_q >= NodeCw'(TreeNodes)) begin
              if (emit_ok) begin
                emit    = 1'b1;
                em_st   = StOverflow;
                phase_d = PH_HALT;
                bk_d    = BK_FLUSH;
              end
            end else if (bit_in) begin
              nodes_d  = nodes_q + 1'b1;
              symcnt_d = SymCw'(1);
              sym_d    = '0;
              consume  = 1'b1;
            end else if (stk_top_q >= StackCw'(StackDepth)) begin
              if (emit_ok) begin
                emit    = 1'b1;
                em_st   = StOverflow;
                phase_d = PH_HALT;
                bk_d    = BK_FLUSH;
              end
            end else begin
              tbl_we    = 1'b1;
              tbl_wa    = nodes_q[NodeAw-1:0];
              tbl_wd    = '0;
              stk_we    = 1'b1;
              stk_top_d = stk_top_q + 1'b1;
              nodes_d   = nodes_q + 1'b1;
              consume   = 1'b1;
            end
          end
          PH_DECODE: begin
            if (rdv_q) begin
              if (ne[LeafBit]) begin
                if (emit_ok) begin
                  emit    = 1'b1;
                  em_byte = ne[SymW-1:0];
                  walk_d  = '0;
                  c1_d    = root_c1_q;
                  consume = 1'b1;
                end
              end else begin
                walk_d  = nxt;
                c1_d    = ne[NodeAw-1:0];
                consume = 1'b1;
              end
            end
          end
          default: bk_d = BK_FLUSH;
        endcase
      end

      BK_CLOSE: begin
        if (stk_top_q == '0) begin
          if (root_leaf_q) begin
            if (emit_ok) begin
              emit    = 1'b1;
              em_st   = StSingleLeaf;
              phase_d = PH_HALT;
              bk_d    = BK_FLUSH;
            end
          end else begin
            phase_d = PH_DECODE;
            walk_d  = '0;
            c1_d    = root_c1_q;
            bk_d    = (cnt_q == BitCw'(BitsPerByte)) ? BK_FLUSH : BK_BITS;
          end
        end else begin
          stk_top_d = stk_top_q - 1'b1;
          tbl_we    = 1'b1;
          tbl_wa    = stk_rd_q;
          tbl_wd    = {1'b0, nodes_q[NodeAw-1:0]};
          bk_d      = (cnt_q == BitCw'(BitsPerByte)) ? BK_FLUSH : BK_BITS;
        end
      end

      BK_FLUSH: begin
        if (hold_v_q) begin
          if (slot_free) begin
            push      = 1'b1;
            push_last = 1'b1;
            hold_v_d  = 1'b0;
            bk_d      = BK_IDLE;
          end
        end else begin
          bk_d = BK_IDLE;
        end
      end

      default: bk_d = BK_IDLE;
    endcase

    if (consume) begin
      bits_d = bits_q << 1;
      cnt_d  = cnt_q + 1'b1;
      if (bk_d == BK_BITS && cnt_q == BitCw'(BitsPerByte - 1)) begin
        bk_d = BK_FLUSH;
      end
    end

    // a new result pushes the held one out; last is known only at item end
    if (emit) begin
      if (hold_v_q) begin
        push = 1'b1;
      end
      hold_v_d    = 1'b1;
      hold_byte_d = em_byte;
      hold_st_d   = em_st;
    end
  end

  always_comb begin
    root_c1_d   = root_c1_q;
    root_leaf_d = root_leaf_q;
    if (tbl_we && tbl_wa == '0) begin
      root_c1_d   = tbl_wd[NodeAw-1:0];
      root_leaf_d = tbl_wd[LeafBit];
    end
    rdv_d = !tbl_we;
    if (push) begin
      out_v_d    = 1'b1;
      out_byte_d = push_byte;
      out_st_d   = push_st;
      out_last_d = push_last;
    end else begin
      out_v_d    = out_v_q && !out_o.ready;
      out_byte_d = out_byte_q;
      out_st_d   = out_st_q;
      out_last_d = out_last_q;
    end
  end

  // reads follow next-state pointers so data lines up with the registered node
  assign tbl_ra_a = walk_d + 1'b1;
  assign tbl_ra_b = c1_d;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    ra_q <= tbl_mem[tbl_ra_a];
    rb_q <= tbl_mem[tbl_ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_q        <= BK_IDLE;
      phase_q     <= PH_PLAIN;
      nodes_q     <= '0;
      stk_top_q   <= '0;
      walk_q      <= '0;
      c1_q        <= '0;
      root_c1_q   <= '0;
      root_leaf_q <= 1'b0;
      sym_q       <= '0;
      symcnt_q    <= '0;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      bk_q        <= bk_d;
      phase_q     <= phase_d;
      nodes_q     <= nodes_d;
      stk_top_q   <= stk_top_d;
      walk_q      <= walk_d;
      c1_q        <= c1_d;
      root_c1_q   <= root_c1_d;
      root_leaf_q <= root_leaf_d;
      sym_q       <= sym_d;
      symcnt_q    <= symcnt_d;
      cnt_q       <= cnt_d;
      rdv_q       <= rdv_d;
      hold_v_q    <= hold_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q      <= bits_d;
    hold_byte_q <= hold_byte_d;
    hold_st_q   <= hold_st_d;
    out_byte_q  <= out_byte_d;
    out_st_q    <= out_st_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid    = out_v_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.status   = out_st_q;
  assign out_o.last     = out_last_q;

  a_tbl_write_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> phase_q == PH_TREE)
    else $error("node table written outside tree load");

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_q == BK_IDLE |-> !hold_v_q)
    else $error("held result left behind at item end");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_top_q <= StackCw'(StackDepth))
    else $error("pending stack beyond depth");

  a_push_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_v_q |-> out_o.ready)
    else $error("output register overwritten while stalled");

endmodule

// ===== hdl/prefix_tree_huffman_decoder_top.sv =====
// Streaming Huffman decoder with a preorder-serialized code tree.
//
// Channels: in_i carries one beat per stream action (action, data_byte);
// out_o carries result beats (out_byte, status, last). A beat moves when
// valid and ready are both high. last marks the final result of an input beat;
// begin, end and halted data beats produce no result at all.
//
// Flow: an input beat lands in a two-deep queue, so the input keeps taking
// beats while the back end works or the output stalls, until the queue is
// full. Begin/end are handled at the pop; a plain byte is popped and
// flushed. A compressed byte is popped, its 8 bits are walked at one per
// cycle unless the output stalls, and it is flushed; while the tree loads,
// each finished leaf adds a child-pointer patch step. The bit loop is bound
// by the node-table read: both children of the current node are read every
// cycle and the bit picks one; the patch step covers the read after a write.
//
// Reset clears all control state and enters plain pass-through; the node table
// and pending stack are not cleared and are always written before use.
// When out_o stalls, the back end holds at the next bit that would produce
// a result; the queue then fills and in_i.ready drops.
module prefix_tree_huffman_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  phd_in_if.sink    in_i,
  phd_out_if.source out_o
);
  import phd_pkg::*;

  head_t head;
  logic  pop;

  // accept, classify, queue
  phd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // tree load, bit walk, result register
  phd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import phd_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  // Slowest correct run is well under CycleLimit: ~360 beats, each at most
  // 8 results, each of which may be stalled, plus gaps and the long hold.
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomBeats = 320;
  localparam int unsigned CalmTail    = 60;
  localparam int unsigned LongHoldAt  = 60;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic [1:0]      st;
    logic            last;
  } result_t;

  typedef struct {
    logic [1:0]      act;
    logic [SymW-1:0] data;
    bit              drain;
  } beat_t;

  // Tracks the decoder state and holds the result beats still owed by the block
  class huff_scoreboard;
    logic [EntryW-1:0]  node_tbl [TreeNodes];
    logic [NodeAw-1:0]  pend_stk [StackDepth];
    logic [StackCw-1:0] stk_top    = '0;
    logic [NodeCw-1:0]  nodes_used = '0;
    logic [NodeAw-1:0]  walk       = '0;
    phase_e             phase      = PH_PLAIN;
    logic [SymW-1:0]    sym_acc    = '0;
    logic [3:0]         sym_cnt    = '0;
    result_t            decoded_q[$];
    int unsigned        mismatches = 0;
    int unsigned        checked    = 0;

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void note_beat(logic [1:0] act, logic [SymW-1:0] d);
      result_t           got[$];
      logic              b;
      logic [EntryW-1:0] ent;
      logic [EntryW-1:0] nxt_ent;
      logic [NodeAw-1:0] nxt;
      case (act)
        ActBegin: begin
          nodes_used = '0;
          stk_top    = '0;
          sym_cnt    = '0;
          sym_acc    = '0;
          walk       = '0;
          phase      = PH_TREE;
          return;
        end
        ActEnd: begin
          sym_cnt = '0;
          sym_acc = '0;
          walk    = '0;
          phase   = PH_PLAIN;
          return;
        end
        ActData: ;
        default: return;
      endcase

      if (phase == PH_PLAIN) begin
        got.push_back('{d, StData, 1'b0});
      end else begin
        for (int k = SymW - 1; k >= 0; k--) begin
          b = d[k];
          if (phase == PH_TREE) begin
            if (sym_cnt != 0) begin
              // collecting a leaf symbol
              sym_acc = {sym_acc[SymW-2:0], b};
              sym_cnt++;
              if (sym_cnt == SymW + 1) begin
                node_tbl[NodeAw'(nodes_used - 1)] = {1'b1, 1'b0, sym_acc};
                sym_cnt = '0;
                sym_acc = '0;
                if (stk_top == 0) begin
                  if (node_tbl[0][LeafBit]) begin
                    got.push_back('{'0, StSingleLeaf, 1'b0});
                    phase = PH_HALT;
                  end else begin
                    phase = PH_DECODE;
                    walk  = '0;
                  end
                end else begin
                  // zero subtree done: patch parent's one-child pointer
                  stk_top--;
                  node_tbl[pend_stk[StackAw'(stk_top)]] = {1'b0, NodeAw'(nodes_used)};
                end
              end
            end else if (nodes_used >= TreeNodes || (!b && stk_top >= StackDepth)) begin
              got.push_back('{'0, StOverflow, 1'b0});
              phase = PH_HALT;
            end else if (b) begin
              nodes_used++;
              sym_cnt = 1;
              sym_acc = '0;
            end else begin
              node_tbl[NodeAw'(nodes_used)] = '0;
              pend_stk[StackAw'(stk_top)]   = NodeAw'(nodes_used);
              stk_top++;
              nodes_used++;
            end
          end else if (phase == PH_DECODE) begin
            ent     = node_tbl[walk];
            nxt     = b ? ent[NodeAw-1:0] : walk + 1'b1;
            nxt_ent = node_tbl[nxt];
            if (nxt_ent[LeafBit]) begin
              got.push_back('{nxt_ent[SymW-1:0], StData, 1'b0});
              walk = '0;
            end else begin
              walk = nxt;
            end
          end
        end
      end
      if (got.size() != 0) got[got.size()-1].last = 1'b1;
      foreach (got[i]) decoded_q.push_back(got[i]);
    endfunction

    function void check_beat(logic [SymW-1:0] sym, logic [1:0] st, logic last);
      result_t want;
      checked++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result %0d: none expected, got byte %02h status %0d last %0b",
                   checked, sym, st, last);
        return;
      end
      want = decoded_q.pop_front();
      if (sym !== want.sym || st !== want.st || last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"result %0d: expected byte %02h status %0d last %0b,",
                    " got byte %02h status %0d last %0b"},
                   checked, want.sym, want.st, want.last, sym, st, last);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  phd_in_if  in_if ();
  phd_out_if out_if ();

  prefix_tree_huffman_decoder_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  huff_scoreboard sb = new;

  beat_t       stim_q[$];
  bit          bit_q[$];
  bit          drain_next     = 1'b0;
  bit          calm           = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned beats_made     = 0;
  int unsigned beats_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned members_made   = 0;
  int unsigned faults_made    = 0;
  int unsigned stall_left     = 0;
  int unsigned cycles         = 0;

  // ---------------------------------------------------------------- stimulus
  function automatic void add_beat(logic [1:0] act, logic [SymW-1:0] d);
    stim_q.push_back('{act, d, drain_next});
    drain_next = 1'b0;
    if (act != IT_NOP) beats_made++;
  endfunction

  // n bits of v, most significant first
  function automatic void add_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
  endfunction

  // turns the bit queue into data beats; the last byte gets random fill
  function automatic void pack_bits();
    logic [SymW-1:0] byte_v;
    while (bit_q.size() % SymW != 0) bit_q.push_back(1'($urandom));
    while (bit_q.size() != 0) begin
      for (int i = 0; i < SymW; i++) byte_v = {byte_v[SymW-2:0], bit_q.pop_front()};
      add_beat(ActData, byte_v);
    end
  endfunction

  function automatic logic [SymW-1:0] pick_sym();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SymW'($urandom);
    endcase
  endfunction

  // Random full tree in preorder, root always internal. open_slots counts
  // subtrees owed; forcing leaves at leaves+open_slots >= max_leaves caps size.
  function automatic void add_tree(int unsigned max_leaves);
    int unsigned open_slots = 1;
    int unsigned leaves     = 0;
    bit          first_node = 1'b1;
    bit          is_leaf;
    while (open_slots != 0) begin
      if (first_node) is_leaf = 1'b0;
      else if (leaves + open_slots >= max_leaves) is_leaf = 1'b1;
      else is_leaf = 1'($urandom_range(0, 1));
      first_node = 1'b0;
      if (is_leaf) begin
        add_bits({1'b1, pick_sym()}, SymW + 1);
        open_slots--;
        leaves++;
      end else begin
        add_bits(0, 1);
        open_slots++;
      end
    end
  endfunction

  // --------------------------------------------------------------- drivers
  task automatic send_beat(beat_t bt);
    in_if.valid     <= 1'b1;
    in_if.action    <= bt.act;
    in_if.data_byte <= bt.data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_beat(bt.act, bt.data);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold to back up the input side,
  // quiet stretches, and no new stalls near the end.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!long_hold_done && beats_sent >= LongHoldAt) begin
      out_if.ready   <= 1'b0;
      stall_left     <= LongHold - 1;
      long_hold_done <= 1'b1;
    end else if (!calm && (cycles % 128) >= 32 && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 7);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_beat(out_if.out_byte, out_if.status, out_if.last);
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    bit          big_done;
    in_if.valid     = 1'b0;
    in_if.action    = ActData;
    in_if.data_byte = '0;
    big_done        = 1'b0;

    // ---- directed: plain bytes at the extremes, ignored action
    add_beat(ActData, 8'h00);
    add_beat(ActData, 8'hFF);
    add_beat(IT_NOP, 8'hFF);
    // two leaves 00/FF; code bits start inside the last tree byte
    add_beat(ActBegin, 8'hFF);
    add_bits(0, 1);
    add_bits(9'h100, 9);
    add_bits(9'h1FF, 9);
    add_bits(13'h1A5C, 13);
    pack_bits();
    add_beat(ActEnd, 8'h00);
    add_beat(ActData, 8'hC3);
    // tree whose root is a leaf, then a byte dropped while halted
    add_beat(ActBegin, 8'h5A);
    add_bits(9'h1A5, 9);
    pack_bits();
    add_beat(ActData, 8'h81);
    add_beat(ActEnd, 8'hFF);
    // begin mid-way through a tree restarts loading; member left open
    add_beat(ActBegin, 8'h00);
    add_beat(ActData, 8'h00);
    add_beat(ActBegin, 8'h3C);
    add_bits(2'b00, 2);
    add_bits({1'b1, 8'h01}, 9);
    add_bits({1'b1, 8'h80}, 9);
    add_bits({1'b1, 8'h7E}, 9);
    add_bits(3'b110, 3);
    pack_bits();
    // empty member, then pass-through again
    add_beat(ActBegin, 8'hAA);
    add_beat(ActEnd, 8'h55);
    add_beat(ActData, 8'h3C);

    // ---- random members
    drain_next = 1'b1;
    while (beats_made < RandomBeats + 25) begin
      if (!big_done && beats_made > RandomBeats / 2) begin
        // node table overflow: 256 pending internals, then leaf/internal pairs
        // until all 512 nodes are used; the next node bit overflows
        big_done   = 1'b1;
        drain_next = 1'b1;
        faults_made++;
        add_beat(ActBegin, SymW'($urandom));
        repeat (StackDepth / SymW) add_beat(ActData, 8'h00);
        repeat ((TreeNodes - StackDepth) / 2) begin
          add_bits({1'b1, pick_sym()}, SymW + 1);
          add_bits(0, 1);
        end
        add_bits($urandom, 12);
        pack_bits();
        add_beat(ActData, SymW'($urandom));
        add_beat(ActEnd, SymW'($urandom));
      end
      kind = $urandom_range(0, 19);
      if (kind == 17) begin
        add_beat(ActBegin, SymW'($urandom));
        repeat ($urandom_range(1, 2)) add_beat(ActData, SymW'($urandom));
      end
      if (kind < 12 || kind == 17) begin
        members_made++;
        add_beat(ActBegin, SymW'($urandom));
        add_tree(($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8));
        repeat ($urandom_range(0, 48)) bit_q.push_back(1'($urandom));
        pack_bits();
        if ($urandom_range(0, 9) != 0) add_beat(ActEnd, SymW'($urandom));
      end else if (kind < 14) begin
        repeat ($urandom_range(1, 6)) add_beat(ActData, pick_sym());
      end else if (kind == 14) begin
        faults_made++;
        add_beat(ActBegin, SymW'($urandom));
        add_bits({1'b1, pick_sym()}, SymW + 1);
        repeat ($urandom_range(0, 16)) bit_q.push_back(1'($urandom));
        pack_bits();
        add_beat(ActEnd, SymW'($urandom));
      end else if (kind == 15) begin
        // pending stack overflow: 257 internal nodes in a row
        faults_made++;
        add_beat(ActBegin, SymW'($urandom));
        repeat (StackDepth / SymW) add_beat(ActData, 8'h00);
        add_beat(ActData, {1'b0, 7'($urandom)});
        repeat ($urandom_range(1, 3)) add_beat(ActData, SymW'($urandom));
        add_beat(ActEnd, SymW'($urandom));
      end else if (kind == 16) begin
        add_beat(ActBegin, SymW'($urandom));
        repeat ($urandom_range(1, 4)) add_beat(ActData, SymW'($urandom));
        if ($urandom_range(0, 1) != 0) add_beat(ActEnd, SymW'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) add_beat(2'($urandom), SymW'($urandom));
      end
    end
    add_beat(ActEnd, 8'h00);
    add_beat(ActData, 8'hF0);

    // ---- run
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    foreach (stim_q[i]) begin
      calm = (i + CalmTail >= stim_q.size());
      if (stim_q[i].drain) begin
        idle_cycles(1);
        while (sb.pending() != 0) @(negedge clk_i);
      end else if (!calm && (i % 64) >= 16 && $urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 8));
      end
      send_beat(stim_q[i]);
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d input beats: %0d decoded members, %0d broken trees, plain and noise",
             beats_sent, members_made, faults_made);
    $display("checked %0d result beats, %0d mismatches, long output hold of %0d cycles",
             results_seen, sb.mismatches, LongHold);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
